[hw/rtl/fss_pkg.sv]
// Shared constants for the filtered sample splat block.
`default_nettype none
package fss_pkg;

    // Default sizes.
    localparam int KERNEL_SIZE  = 16;
    localparam int IMAGE_WIDTH  = 64;
    localparam int IMAGE_HEIGHT = 64;
    localparam int MAX_RADIUS   = 4;

    // Operation codes carried in tuser of the input beat.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SPLAT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_HALF_WIDTH_X    = 3'd0;
    localparam logic [2:0] REG_HALF_WIDTH_Y    = 3'd1;
    localparam logic [2:0] REG_INVERSE_WIDTH_X = 3'd2;
    localparam logic [2:0] REG_INVERSE_WIDTH_Y = 3'd3;
    localparam logic [2:0] REG_WINDOW_X_START  = 3'd4;
    localparam logic [2:0] REG_WINDOW_X_COUNT  = 3'd5;
    localparam logic [2:0] REG_WINDOW_Y_START  = 3'd6;
    localparam logic [2:0] REG_WINDOW_Y_COUNT  = 3'd7;

    // Result status codes.
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    // Beat widths.
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 184;
    localparam int CFG_DATA_W = 15;

endpackage
`default_nettype wire

[hw/rtl/fss_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module fss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/filtered_sample_splat.sv]
// Top level of the filtered sample splat block: sequencer, shared multiplier and stores.
//
// The block splats image samples into a pixel accumulation buffer through a
// filter weight table, loads table words and reads back one pixel's sums. After
// reset a clearing pass zeroes the weight table and the pixel buffer, during
// which no input beat is taken while configuration writes still land. A splat
// walks the covered rectangle row by row, and skips the walk with the outside
// status when it misses the window; a default half-width of two pixels covers
// four or five pixels per axis. Splat time is set by the one multiplier that
// serves the table index math, the row base and the three color products in
// turn, and by the single read-modify-write pixel port. One item is worked on
// at a time; the next input beat is taken while a result beat still waits in
// the output register.
`default_nettype none
module filtered_sample_splat #(
    parameter int KERNEL_SIZE  = fss_pkg::KERNEL_SIZE,
    parameter int IMAGE_WIDTH  = fss_pkg::IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = fss_pkg::IMAGE_HEIGHT,
    parameter int MAX_RADIUS   = fss_pkg::MAX_RADIUS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_x, sample_y, red, green, blue, table_index, table_weight,
    // pixel_index, then zero fill
    input  wire logic [fss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  wire logic [1:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // red_sum, green_sum, blue_sum, weight_sum
    output logic [fss_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status
    output logic                                m_axis_tuser,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TABLE_WORDS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIXEL_WORDS = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int CLEAR_WORDS = (PIXEL_WORDS > TABLE_WORDS) ? PIXEL_WORDS : TABLE_WORDS;
    localparam int TW  = $clog2(TABLE_WORDS);
    localparam int PW  = $clog2(PIXEL_WORDS);
    localparam int CLW = $clog2(CLEAR_WORDS);
    localparam int KW  = $clog2(KERNEL_SIZE);
    localparam int MAX_HW = MAX_RADIUS * 256;
    localparam int AW  = $clog2(MAX_HW + 1);
    localparam int IMG_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int CW  = $clog2(IMG_MAX + 320) + 1;
    localparam int DW  = CW + 10;
    localparam int FW  = 41;
    localparam int SW  = 5;

    localparam logic [SW-1:0] S_CLEAR = 5'd0;
    localparam logic [SW-1:0] S_IDLE  = 5'd1;
    localparam logic [SW-1:0] S_BOUND = 5'd2;
    localparam logic [SW-1:0] S_CLAMP = 5'd3;
    localparam logic [SW-1:0] S_BASE  = 5'd4;
    localparam logic [SW-1:0] S_BASE2 = 5'd5;
    localparam logic [SW-1:0] S_YA    = 5'd6;
    localparam logic [SW-1:0] S_YM    = 5'd7;
    localparam logic [SW-1:0] S_YI    = 5'd8;
    localparam logic [SW-1:0] S_XA    = 5'd9;
    localparam logic [SW-1:0] S_XM    = 5'd10;
    localparam logic [SW-1:0] S_XI    = 5'd11;
    localparam logic [SW-1:0] S_TW    = 5'd12;
    localparam logic [SW-1:0] S_MG    = 5'd13;
    localparam logic [SW-1:0] S_MB    = 5'd14;
    localparam logic [SW-1:0] S_WR    = 5'd15;
    localparam logic [SW-1:0] S_RDW   = 5'd16;
    localparam logic [SW-1:0] S_DONE  = 5'd17;

    // Configuration.
    logic [10:0] r_hw_x, r_hw_y;
    logic [14:0] r_inv_x, r_inv_y;
    logic [5:0]  r_wxs, r_wys;
    logic [6:0]  r_wxc, r_wyc;

    logic [SW-1:0]        r_state;
    logic [CLW-1:0]       r_clr;
    logic signed [16:0]   r_dx, r_dy;
    logic [15:0]          r_red, r_grn, r_blu;
    logic signed [CW-1:0] r_x0, r_x1, r_y0, r_y1, r_x, r_y;
    logic [PW-1:0]        r_rowbase, r_p;
    logic [AW-1:0]        r_a;
    logic [KW-1:0]        r_ty;
    logic signed [15:0]   r_w;
    logic signed [34:0]   r_prod;
    logic [47:0]          r_nred, r_ngrn;
    logic                 r_rd_ok;
    logic                 r_pst;
    logic [fss_pkg::OUT_DATA_W-1:0] r_pdata;
    logic                 r_ovalid;
    logic                 r_ostatus;
    logic [fss_pkg::OUT_DATA_W-1:0] r_odata;

    // Input beat fields.
    logic [15:0] in_sx, in_sy, in_red, in_grn, in_blu, in_tw;
    logic [7:0]  in_ti;
    logic [11:0] in_pi;
    assign in_sx  = s_axis_tdata[15:0];
    assign in_sy  = s_axis_tdata[31:16];
    assign in_red = s_axis_tdata[47:32];
    assign in_grn = s_axis_tdata[63:48];
    assign in_blu = s_axis_tdata[79:64];
    assign in_ti  = s_axis_tdata[87:80];
    assign in_tw  = s_axis_tdata[103:88];
    assign in_pi  = s_axis_tdata[115:104];

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Window counts, with zero taken as one and saturation at the image size.
    function automatic logic signed [CW-1:0] clamp_cnt(input logic [6:0] c, input int lim);
        logic signed [CW-1:0] v;
        if (c == 7'd0) begin
            v = CW'(1);
        end else if (32'(c) > lim) begin
            v = CW'(lim);
        end else begin
            v = CW'(c);
        end
        return v;
    endfunction

    logic signed [CW-1:0] xcc, ycc, xs_c, ys_c, xe, ye;
    assign xcc  = clamp_cnt(r_wxc, IMAGE_WIDTH);
    assign ycc  = clamp_cnt(r_wyc, IMAGE_HEIGHT);
    assign xs_c = CW'(r_wxs);
    assign ys_c = CW'(r_wys);
    assign xe   = xs_c + xcc - CW'(1);
    assign ye   = ys_c + ycc - CW'(1);

    // Raw covered rectangle from the clamped half-widths.
    logic [AW-1:0]      hx_c, hy_c;
    logic signed [18:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [19:0] cl_x, cl_y;
    logic signed [19:0] sh_lx, sh_hx, sh_ly, sh_hy;
    assign hx_c = (12'(r_hw_x) > 12'(MAX_HW)) ? AW'(MAX_HW) : AW'(r_hw_x);
    assign hy_c = (12'(r_hw_y) > 12'(MAX_HW)) ? AW'(MAX_HW) : AW'(r_hw_y);
    assign lo_x = 19'(r_dx) - $signed(19'(hx_c));
    assign hi_x = 19'(r_dx) + $signed(19'(hx_c));
    assign lo_y = 19'(r_dy) - $signed(19'(hy_c));
    assign hi_y = 19'(r_dy) + $signed(19'(hy_c));
    assign cl_x = 20'(lo_x) + 20'sd255;
    assign cl_y = 20'(lo_y) + 20'sd255;
    assign sh_lx = cl_x >>> 8;
    assign sh_ly = cl_y >>> 8;
    assign sh_hx = 20'(hi_x) >>> 8;
    assign sh_hy = 20'(hi_y) >>> 8;

    // Distance from pixel center to sample, per axis.
    logic signed [DW-1:0] dfx, dfy, abx, aby;
    assign dfx = ($signed(DW'(r_x)) <<< 8) - DW'(r_dx);
    assign dfy = ($signed(DW'(r_y)) <<< 8) - DW'(r_dy);
    assign abx = (dfx < 0) ? -dfx : dfx;
    assign aby = (dfy < 0) ? -dfy : dfy;

    // Table index from distance times inverse width.
    logic [FW-1:0] fk, fsh;
    logic [KW-1:0] tidx;
    assign fk   = FW'(r_prod[33:0]) * FW'(KERNEL_SIZE);
    assign fsh  = fk >> 22;
    assign tidx = (fsh > FW'(KERNEL_SIZE - 1)) ? KW'(KERNEL_SIZE - 1) : fsh[KW-1:0];

    // Memories.
    logic          tbl_we;
    logic [TW-1:0] tbl_waddr, tbl_raddr;
    logic [15:0]   tbl_wdata, tbl_rdata;
    logic          pix_we;
    logic [PW-1:0] pix_waddr, pix_raddr, pix_addr_splat;
    logic [fss_pkg::OUT_DATA_W-1:0] pix_wdata, pix_rdata;
    logic          load_ok, read_ok;

    assign load_ok = (32'(in_ti) < TABLE_WORDS);
    assign read_ok = (32'(in_pi) < PIXEL_WORDS);

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_clr[TW-1:0];
        tbl_wdata = '0;
        if (r_state == S_CLEAR) begin
            tbl_we = (32'(r_clr) < TABLE_WORDS);
        end else if (accept && s_axis_tuser == fss_pkg::OP_LOAD && load_ok) begin
            tbl_we    = 1'b1;
            tbl_waddr = TW'(in_ti);
            tbl_wdata = in_tw;
        end
    end

    assign tbl_raddr = TW'(r_ty * KERNEL_SIZE) + TW'(tidx);
    assign pix_addr_splat = r_rowbase + PW'(r_x - xs_c);
    assign pix_raddr = (r_state == S_IDLE) ? PW'(in_pi) : pix_addr_splat;

    always_comb begin
        if (r_state == S_CLEAR) begin
            pix_we    = (32'(r_clr) < PIXEL_WORDS);
            pix_waddr = r_clr[PW-1:0];
            pix_wdata = '0;
        end else begin
            pix_we    = (r_state == S_WR);
            pix_waddr = r_p;
            pix_wdata = {pix_rdata[183:144] + 40'(r_w),
                         pix_rdata[143:96] + 48'(r_prod),
                         r_ngrn, r_nred};
        end
    end

    fss_ram #(.WIDTH(16), .DEPTH(TABLE_WORDS)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    fss_ram #(.WIDTH(fss_pkg::OUT_DATA_W), .DEPTH(PIXEL_WORDS)) u_pixels (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    // The shared multiplier; operands are picked by the sequencer state.
    logic signed [17:0] m_a;
    logic signed [16:0] m_b;
    always_comb begin
        case (r_state)
            S_BASE: begin
                m_a = 18'(r_y0 - ys_c);
                m_b = 17'(xcc);
            end
            S_YM: begin
                m_a = 18'(r_a);
                m_b = 17'(r_inv_y);
            end
            S_XM: begin
                m_a = 18'(r_a);
                m_b = 17'(r_inv_x);
            end
            S_TW: begin
                m_a = 18'($signed(tbl_rdata));
                m_b = 17'(r_red);
            end
            S_MG: begin
                m_a = 18'(r_w);
                m_b = 17'(r_grn);
            end
            S_MB: begin
                m_a = 18'(r_w);
                m_b = 17'(r_blu);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw_x  <= 11'd512;
            r_hw_y  <= 11'd512;
            r_inv_x <= 15'd8192;
            r_inv_y <= 15'd8192;
            r_wxs   <= 6'd0;
            r_wys   <= 6'd0;
            r_wxc   <= 7'd64;
            r_wyc   <= 7'd64;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fss_pkg::REG_HALF_WIDTH_X:    r_hw_x  <= i_cfg_data[10:0];
                fss_pkg::REG_HALF_WIDTH_Y:    r_hw_y  <= i_cfg_data[10:0];
                fss_pkg::REG_INVERSE_WIDTH_X: r_inv_x <= i_cfg_data[14:0];
                fss_pkg::REG_INVERSE_WIDTH_Y: r_inv_y <= i_cfg_data[14:0];
                fss_pkg::REG_WINDOW_X_START:  r_wxs   <= i_cfg_data[5:0];
                fss_pkg::REG_WINDOW_X_COUNT:  r_wxc   <= i_cfg_data[6:0];
                fss_pkg::REG_WINDOW_Y_START:  r_wys   <= i_cfg_data[5:0];
                fss_pkg::REG_WINDOW_Y_COUNT:  r_wyc   <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLW'(1);
                    if (32'(r_clr) == CLEAR_WORDS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_dx    <= 17'($signed(in_sx)) - 17'sd128;
                        r_dy    <= 17'($signed(in_sy)) - 17'sd128;
                        r_red   <= in_red;
                        r_grn   <= in_grn;
                        r_blu   <= in_blu;
                        r_rd_ok <= read_ok;
                        r_pst   <= fss_pkg::STATUS_DONE;
                        r_pdata <= '0;
                        case (s_axis_tuser)
                            fss_pkg::OP_SPLAT: r_state <= S_BOUND;
                            fss_pkg::OP_READ:  r_state <= S_RDW;
                            default:           r_state <= S_DONE;
                        endcase
                    end
                end
                S_BOUND: begin
                    r_x0    <= CW'(sh_lx);
                    r_x1    <= CW'(sh_hx);
                    r_y0    <= CW'(sh_ly);
                    r_y1    <= CW'(sh_hy);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    logic signed [CW-1:0] cx0, cx1, cy0, cy1;
                    cx0 = (r_x0 < xs_c) ? xs_c : r_x0;
                    cx1 = (r_x1 > xe) ? xe : r_x1;
                    cy0 = (r_y0 < ys_c) ? ys_c : r_y0;
                    cy1 = (r_y1 > ye) ? ye : r_y1;
                    r_x0 <= cx0;
                    r_x1 <= cx1;
                    r_y0 <= cy0;
                    r_y1 <= cy1;
                    r_y  <= cy0;
                    if (cx1 < cx0 || cy1 < cy0) begin
                        r_pst   <= fss_pkg::STATUS_OUTSIDE;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_state <= S_BASE2;
                end
                S_BASE2: begin
                    r_rowbase <= PW'(r_prod);
                    r_state   <= S_YA;
                end
                S_YA: begin
                    r_a     <= AW'(aby);
                    r_state <= S_YM;
                end
                S_YM: begin
                    r_state <= S_YI;
                end
                S_YI: begin
                    r_ty    <= tidx;
                    r_x     <= r_x0;
                    r_state <= S_XA;
                end
                S_XA: begin
                    r_a     <= AW'(abx);
                    r_state <= S_XM;
                end
                S_XM: begin
                    r_state <= S_XI;
                end
                S_XI: begin
                    // Table and pixel reads go out here; data comes back next cycle.
                    r_p     <= pix_addr_splat;
                    r_state <= S_TW;
                end
                S_TW: begin
                    r_w     <= $signed(tbl_rdata);
                    r_state <= S_MG;
                end
                S_MG: begin
                    r_nred  <= pix_rdata[47:0] + 48'(r_prod);
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_ngrn  <= pix_rdata[95:48] + 48'(r_prod);
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_x < r_x1) begin
                        r_x     <= r_x + CW'(1);
                        r_state <= S_XA;
                    end else if (r_y < r_y1) begin
                        r_y       <= r_y + CW'(1);
                        r_rowbase <= r_rowbase + PW'(xcc);
                        r_state   <= S_YA;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RDW: begin
                    r_pdata <= r_rd_ok ? pix_rdata : '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ostatus <= r_pst;
            r_odata   <= r_pdata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostatus;

    // Every accumulate lands on a pixel inside the clamped rectangle.
    a_pixel_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_x >= r_x0 && r_x <= r_x1 && r_y >= r_y0 && r_y <= r_y1))
        else $error("accumulate outside covered rectangle");

    // The row-major buffer address never runs past the buffer.
    a_pixel_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (32'(r_p) < PIXEL_WORDS))
        else $error("pixel address past buffer end");

    // A waiting result beat is never overwritten by the next item.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata) && $stable(r_ostatus)))
        else $error("result beat lost while stalled");

endmodule
`default_nettype wire
